// ===== hdl/olsd_pkg.sv =====
// ----------------------------------------------------------------------------
// olsd_pkg: shared types for the ordered list store
// Request and status codes, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package olsd_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned ValW    = 8;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FidxW   = 5;
  localparam int unsigned FillW   = 6;

  typedef enum logic [OpW-1:0] {
    OP_APPEND       = 3'd0,
    OP_FIND         = 3'd1,
    OP_REMOVE_VALUE = 3'd2,
    OP_REMOVE_AT    = 3'd3,
    OP_REMOVE_LAST  = 3'd4,
    OP_CLEAR        = 3'd5,
    OP_READ         = 3'd6,
    OP_WRITE        = 3'd7
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // Where the walk index is loaded from.
  typedef enum logic [2:0] {
    IDX_ZERO,
    IDX_POS,
    IDX_POS_NEXT,
    IDX_HIT_NEXT,
    IDX_TAIL
  } idx_src_e;

  typedef struct packed {
    logic     load;
    logic     idx_ld;
    idx_src_e idx_src;
    logic     rd_en;
    logic     shift_wr;
    logic     app_wr;
    logic     pos_wr;
    logic     cnt_dec;
    logic     cnt_clr;
    logic     res_ld;
    status_e  res_status;
    logic     res_fidx;
    logic     res_rval;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic pos_ok;
    logic idx_end;
    logic pvld;
    logic hit;
    logic last_cmp;
  } sts_t;

endpackage

// ===== hdl/olsd_dpath.sv =====
// ----------------------------------------------------------------------------
// olsd_dpath: datapath of the ordered list store
// Entry memory, fill count, walk index with its read pipeline, and the
// result and output registers.
// ----------------------------------------------------------------------------
module olsd_dpath #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  olsd_pkg::cmd_t               cmd_i,
  output olsd_pkg::sts_t               sts_o,
  input  olsd_pkg::op_e                op_i,
  input  logic [olsd_pkg::ValW-1:0]    item_value_i,
  input  logic [olsd_pkg::PosW-1:0]    position_i,
  output olsd_pkg::status_e            status_o,
  output logic [olsd_pkg::FidxW-1:0]   found_index_o,
  output logic [olsd_pkg::ValW-1:0]    read_value_o,
  output logic [olsd_pkg::FillW-1:0]   fill_count_o
);

  localparam int unsigned IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned ExtW = (CW > olsd_pkg::FillW) ? CW : olsd_pkg::FillW;

  logic [olsd_pkg::ValW-1:0] mem_q [CAPACITY];

  olsd_pkg::op_e             op_q;
  logic [olsd_pkg::ValW-1:0] val_q;
  logic [olsd_pkg::PosW-1:0] pos_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pidx_q;
  logic          pvld_q, pvld_d;
  logic [olsd_pkg::ValW-1:0] rd_data_q;

  olsd_pkg::status_e          res_status_q;
  logic [olsd_pkg::FidxW-1:0] res_fidx_q;
  logic [olsd_pkg::ValW-1:0]  res_rval_q;

  olsd_pkg::status_e          out_status_q;
  logic [olsd_pkg::FidxW-1:0] out_fidx_q;
  logic [olsd_pkg::ValW-1:0]  out_rval_q;
  logic [olsd_pkg::FillW-1:0] out_fill_q;

  logic [ExtW-1:0] pos_ext, count_ext, pidx_ext;
  logic [CW-1:0]   pidx_prev;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  logic [olsd_pkg::ValW-1:0] mem_wd;

  assign pos_ext   = ExtW'(pos_q);
  assign count_ext = ExtW'(count_q);
  assign pidx_ext  = ExtW'(pidx_q);
  assign pidx_prev = pidx_q - CW'(1);

  assign sts_o.op       = op_q;
  assign sts_o.full     = (count_q == CW'(CAPACITY));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.pos_ok   = (pos_ext < count_ext);
  assign sts_o.idx_end  = (idx_q == count_q);
  assign sts_o.pvld     = pvld_q;
  assign sts_o.hit      = pvld_q && (rd_data_q == val_q);
  assign sts_o.last_cmp = pvld_q && ((pidx_q + CW'(1)) == count_q);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_ld) begin
      case (cmd_i.idx_src)
        olsd_pkg::IDX_ZERO:     idx_d = '0;
        olsd_pkg::IDX_POS:      idx_d = pos_ext[CW-1:0];
        olsd_pkg::IDX_POS_NEXT: idx_d = pos_ext[CW-1:0] + CW'(1);
        olsd_pkg::IDX_HIT_NEXT: idx_d = pidx_q + CW'(1);
        olsd_pkg::IDX_TAIL:     idx_d = count_q - CW'(1);
        default:                idx_d = '0;
      endcase
    end else if (cmd_i.rd_en) begin
      idx_d = idx_q + CW'(1);
    end
  end

  assign pvld_d = cmd_i.rd_en && !cmd_i.idx_ld;

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.app_wr) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  // One write port: append at the tail, write in place, or move an entry
  // down one place during a removal.
  always_comb begin
    mem_we = cmd_i.app_wr || cmd_i.pos_wr || cmd_i.shift_wr;
    mem_wa = count_q[IW-1:0];
    mem_wd = val_q;
    if (cmd_i.pos_wr) begin
      mem_wa = pos_ext[IW-1:0];
    end else if (cmd_i.shift_wr) begin
      mem_wa = pidx_prev[IW-1:0];
      mem_wd = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[idx_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pvld_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pvld_q  <= pvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.rd_en) begin
      pidx_q <= idx_q;
    end
    if (cmd_i.load) begin
      op_q  <= op_i;
      val_q <= item_value_i;
      pos_q <= position_i;
    end
    if (cmd_i.res_ld) begin
      res_status_q <= cmd_i.res_status;
      res_fidx_q   <= cmd_i.res_fidx ? pidx_ext[olsd_pkg::FidxW-1:0] : '0;
      res_rval_q   <= cmd_i.res_rval ? rd_data_q : '0;
    end
    if (cmd_i.out_ld) begin
      out_status_q <= res_status_q;
      out_fidx_q   <= res_fidx_q;
      out_rval_q   <= res_rval_q;
      out_fill_q   <= count_ext[olsd_pkg::FillW-1:0];
    end
  end

  assign status_o      = out_status_q;
  assign found_index_o = out_fidx_q;
  assign read_value_o  = out_rval_q;
  assign fill_count_o  = out_fill_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_shift_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_wr |-> pvld_q)
    else $error("shift write without read data");

  a_single_tail_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.app_wr |-> (count_q != CW'(CAPACITY)))
    else $error("append into a full store");

endmodule

// ===== hdl/olsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// olsd_ctrl: controller of the ordered list store
// Sequences each request through decode, scan, shift and read steps and
// drives the output handshake.
// ----------------------------------------------------------------------------
module olsd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  olsd_pkg::sts_t sts_i,
  output olsd_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_WAIT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.idx_src    = olsd_pkg::IDX_ZERO;
    cmd_o.res_status = olsd_pkg::ST_OK;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end

      S_DECODE: begin
        cmd_o.res_ld = 1'b1;
        state_d      = S_FINISH;
        case (sts_i.op)
          olsd_pkg::OP_APPEND: begin
            if (sts_i.full) begin
              cmd_o.res_status = olsd_pkg::ST_FULL;
            end else begin
              cmd_o.app_wr = 1'b1;
            end
          end
          olsd_pkg::OP_FIND, olsd_pkg::OP_REMOVE_VALUE: begin
            if (sts_i.empty) begin
              cmd_o.res_status = olsd_pkg::ST_NOT_FOUND;
            end else begin
              cmd_o.res_ld  = 1'b0;
              cmd_o.idx_ld  = 1'b1;
              cmd_o.idx_src = olsd_pkg::IDX_ZERO;
              state_d       = S_SCAN;
            end
          end
          olsd_pkg::OP_REMOVE_AT: begin
            if (!sts_i.pos_ok) begin
              cmd_o.res_status = olsd_pkg::ST_RANGE;
            end else begin
              cmd_o.res_ld  = 1'b0;
              cmd_o.idx_ld  = 1'b1;
              cmd_o.idx_src = olsd_pkg::IDX_POS_NEXT;
              state_d       = S_SHIFT;
            end
          end
          olsd_pkg::OP_REMOVE_LAST: begin
            if (sts_i.empty) begin
              cmd_o.res_status = olsd_pkg::ST_RANGE;
            end else begin
              cmd_o.res_ld  = 1'b0;
              cmd_o.idx_ld  = 1'b1;
              cmd_o.idx_src = olsd_pkg::IDX_TAIL;
              state_d       = S_READ;
            end
          end
          olsd_pkg::OP_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
          end
          olsd_pkg::OP_READ: begin
            if (!sts_i.pos_ok) begin
              cmd_o.res_status = olsd_pkg::ST_RANGE;
            end else begin
              cmd_o.res_ld  = 1'b0;
              cmd_o.idx_ld  = 1'b1;
              cmd_o.idx_src = olsd_pkg::IDX_POS;
              state_d       = S_READ;
            end
          end
          olsd_pkg::OP_WRITE: begin
            if (!sts_i.pos_ok) begin
              cmd_o.res_status = olsd_pkg::ST_RANGE;
            end else begin
              cmd_o.pos_wr = 1'b1;
            end
          end
          default: begin
            cmd_o.res_status = olsd_pkg::ST_RANGE;
          end
        endcase
      end

      // Reads are issued one entry a cycle; each comparison sees the
      // entry read in the cycle before.
      S_SCAN: begin
        if (sts_i.hit) begin
          if (sts_i.op == olsd_pkg::OP_FIND) begin
            cmd_o.res_ld   = 1'b1;
            cmd_o.res_fidx = 1'b1;
            state_d        = S_FINISH;
          end else begin
            cmd_o.idx_ld  = 1'b1;
            cmd_o.idx_src = olsd_pkg::IDX_HIT_NEXT;
            state_d       = S_SHIFT;
          end
        end else if (sts_i.last_cmp) begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = olsd_pkg::ST_NOT_FOUND;
          state_d          = S_FINISH;
        end else begin
          cmd_o.rd_en = !sts_i.idx_end;
        end
      end

      S_SHIFT: begin
        cmd_o.shift_wr = sts_i.pvld;
        cmd_o.rd_en    = !sts_i.idx_end;
        if (sts_i.idx_end && !sts_i.pvld) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.res_ld  = 1'b1;
          state_d       = S_FINISH;
        end
      end

      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_WAIT;
      end

      S_WAIT: begin
        cmd_o.res_ld   = 1'b1;
        cmd_o.res_rval = 1'b1;
        cmd_o.cnt_dec  = (sts_i.op == olsd_pkg::OP_REMOVE_LAST);
        state_d        = S_FINISH;
      end

      S_FINISH: begin
        if (out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_ld) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
    else $error("accepted item not decoded");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> (!out_vld_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_finish_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |=> (out_vld_q && state_q == S_IDLE))
    else $error("finished result not presented");

endmodule

// ===== hdl/ordered_list_store_search_delete_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store_search_delete_unit: ordered byte list with search
// Keeps an ordered list of bytes in a fixed store and serves append, find,
// remove, pop, read, write and clear requests, one result per request.
// ----------------------------------------------------------------------------
// One request is worked on at a time; the input is ready again as soon as
// the result is in the output register, even while that result still waits.
// A remove by value that finds no match costs what an unsuccessful find
// does. The worst case is a removal by value of the head of a full list,
// set by the single read port of the entry memory, which is walked one
// entry a cycle. The memory needs no clearing after reset: only entries
// below the fill count are ever read.
module ordered_list_store_search_delete_unit #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // item_value[7:0], position[12:8], zero
  input  logic [2:0]  s_axis_tuser,  // op[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // found_index[4:0], read_value[12:5],
                                     // fill_count[18:13], zero
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  olsd_pkg::cmd_t cmd;
  olsd_pkg::sts_t sts;

  olsd_pkg::status_e                status;
  logic [olsd_pkg::FidxW-1:0]       found_index;
  logic [olsd_pkg::ValW-1:0]        read_value;
  logic [olsd_pkg::FillW-1:0]       fill_count;

  olsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  olsd_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (olsd_pkg::op_e'(s_axis_tuser)),
    .item_value_i  (s_axis_tdata[7:0]),
    .position_i    (s_axis_tdata[12:8]),
    .status_o      (status),
    .found_index_o (found_index),
    .read_value_o  (read_value),
    .fill_count_o  (fill_count)
  );

  assign m_axis_tdata = {5'b0, fill_count, read_value, found_index};
  assign m_axis_tuser = status;

endmodule
